/* design/haar_feature_from_integral_image_top_macros.svh */
// assertion macros for the haar feature block
`ifndef HAAR_FEATURE_FROM_INTEGRAL_IMAGE_TOP_MACROS_SVH
`define HAAR_FEATURE_FROM_INTEGRAL_IMAGE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define HAAR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("haar assertion failed");
`define HAAR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("haar reset assertion failed");
`else
`define HAAR_ASSERT(lbl, prop)
`define HAAR_ASSERT_RST(lbl, prop)
`endif

`endif

/* design/haar_pkg.sv */
// shared types, constants and microcode for the haar feature block
package haar_pkg;

  localparam int unsigned IMG_WIDTH   = 32;
  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned VAL_W       = 18;
  localparam int unsigned FV_W        = 23;
  localparam int unsigned CW          = 10;
  localparam int unsigned IDX_W       = 2 * CW;
  localparam int unsigned ACC_W       = 26;
  localparam int unsigned PC_W        = 6;
  localparam int unsigned ROM_DEPTH   = 37;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  localparam logic [2:0] KIND_VERT2   = 3'd1;
  localparam logic [2:0] KIND_HORIZ2  = 3'd2;
  localparam logic [2:0] KIND_VERT3   = 3'd3;
  localparam logic [2:0] KIND_HORIZ3  = 3'd4;
  localparam logic [2:0] KIND_CHECKER = 3'd5;

  localparam logic [PC_W-1:0] PC_VERT2   = PC_W'(0);
  localparam logic [PC_W-1:0] PC_HORIZ2  = PC_W'(6);
  localparam logic [PC_W-1:0] PC_VERT3   = PC_W'(12);
  localparam logic [PC_W-1:0] PC_HORIZ3  = PC_W'(20);
  localparam logic [PC_W-1:0] PC_CHECKER = PC_W'(28);

  typedef struct packed {
    logic       action;
    logic [9:0] entry_index;
    logic [17:0] entry_value;
    logic [5:0] origin_x;
    logic [5:0] origin_y;
    logic [5:0] rect_width;
    logic [5:0] rect_height;
    logic [2:0] feature_kind;
  } in_item_t;

  typedef struct packed {
    logic signed [22:0] feature_value;
    logic               error_flag;
  } out_item_t;

  typedef enum logic {OP_STEP, OP_LAST} op_e;
  typedef enum logic [2:0] {XS_ORG, XS_HALF, XS_THIRD1, XS_THIRD2, XS_END} xsel_e;
  typedef enum logic [2:0] {YS_ORG, YS_HALF, YS_THIRD1, YS_THIRD2, YS_END} ysel_e;
  typedef enum logic [2:0] {WT_P1, WT_P2, WT_P4, WT_N1, WT_N2} wt_e;

  typedef struct packed {
    op_e   op;
    xsel_e xs;
    ysel_e ys;
    wt_e   wt;
  } ucode_t;

  typedef struct packed {
    logic  wr;
    logic  load;
    logic  kind_err;
    logic  split;
    logic  issue;
    xsel_e xs;
    ysel_e ys;
    wt_e   wt;
    logic  finish;
  } ctrl_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      // vertical two-rect
      6'd0:  w = '{OP_STEP, XS_END,    YS_END,    WT_P1};
      6'd1:  w = '{OP_STEP, XS_ORG,    YS_HALF,   WT_P2};
      6'd2:  w = '{OP_STEP, XS_END,    YS_HALF,   WT_N2};
      6'd3:  w = '{OP_STEP, XS_ORG,    YS_END,    WT_N1};
      6'd4:  w = '{OP_STEP, XS_ORG,    YS_ORG,    WT_N1};
      6'd5:  w = '{OP_LAST, XS_END,    YS_ORG,    WT_P1};
      // horizontal two-rect
      6'd6:  w = '{OP_STEP, XS_HALF,   YS_END,    WT_P2};
      6'd7:  w = '{OP_STEP, XS_ORG,    YS_ORG,    WT_P1};
      6'd8:  w = '{OP_STEP, XS_HALF,   YS_ORG,    WT_N2};
      6'd9:  w = '{OP_STEP, XS_END,    YS_END,    WT_N1};
      6'd10: w = '{OP_STEP, XS_END,    YS_ORG,    WT_P1};
      6'd11: w = '{OP_LAST, XS_ORG,    YS_END,    WT_N1};
      // vertical three-rect
      6'd12: w = '{OP_STEP, XS_END,    YS_THIRD1, WT_P2};
      6'd13: w = '{OP_STEP, XS_ORG,    YS_THIRD2, WT_P2};
      6'd14: w = '{OP_STEP, XS_ORG,    YS_ORG,    WT_P1};
      6'd15: w = '{OP_STEP, XS_END,    YS_END,    WT_P1};
      6'd16: w = '{OP_STEP, XS_ORG,    YS_THIRD1, WT_N2};
      6'd17: w = '{OP_STEP, XS_END,    YS_THIRD2, WT_N2};
      6'd18: w = '{OP_STEP, XS_END,    YS_ORG,    WT_N1};
      6'd19: w = '{OP_LAST, XS_ORG,    YS_END,    WT_N1};
      // horizontal three-rect
      6'd20: w = '{OP_STEP, XS_THIRD1, YS_END,    WT_P2};
      6'd21: w = '{OP_STEP, XS_THIRD2, YS_ORG,    WT_P2};
      6'd22: w = '{OP_STEP, XS_ORG,    YS_ORG,    WT_P1};
      6'd23: w = '{OP_STEP, XS_END,    YS_END,    WT_P1};
      6'd24: w = '{OP_STEP, XS_THIRD1, YS_ORG,    WT_N2};
      6'd25: w = '{OP_STEP, XS_THIRD2, YS_END,    WT_N2};
      6'd26: w = '{OP_STEP, XS_END,    YS_ORG,    WT_N1};
      6'd27: w = '{OP_LAST, XS_ORG,    YS_END,    WT_N1};
      // checker
      6'd28: w = '{OP_STEP, XS_HALF,   YS_HALF,   WT_P4};
      6'd29: w = '{OP_STEP, XS_ORG,    YS_ORG,    WT_P1};
      6'd30: w = '{OP_STEP, XS_END,    YS_ORG,    WT_P1};
      6'd31: w = '{OP_STEP, XS_ORG,    YS_END,    WT_P1};
      6'd32: w = '{OP_STEP, XS_END,    YS_END,    WT_P1};
      6'd33: w = '{OP_STEP, XS_HALF,   YS_ORG,    WT_N2};
      6'd34: w = '{OP_STEP, XS_ORG,    YS_HALF,   WT_N2};
      6'd35: w = '{OP_STEP, XS_END,    YS_HALF,   WT_N2};
      6'd36: w = '{OP_LAST, XS_HALF,   YS_END,    WT_N2};
      default: w = '{OP_LAST, XS_ORG,  YS_ORG,    WT_P1};
    endcase
    return w;
  endfunction

  function automatic logic kind_ok(input logic [2:0] kind);
    return (kind == KIND_VERT2) || (kind == KIND_HORIZ2) || (kind == KIND_VERT3) ||
           (kind == KIND_HORIZ3) || (kind == KIND_CHECKER);
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] kind);
    logic [PC_W-1:0] pc;
    unique case (kind)
      KIND_VERT2:   pc = PC_VERT2;
      KIND_HORIZ2:  pc = PC_HORIZ2;
      KIND_VERT3:   pc = PC_VERT3;
      KIND_HORIZ3:  pc = PC_HORIZ3;
      KIND_CHECKER: pc = PC_CHECKER;
      default:      pc = PC_VERT2;
    endcase
    return pc;
  endfunction

  // floor(v / 3) for v below 128 by reciprocal multiply
  function automatic logic [5:0] div3(input logic [6:0] v);
    logic [12:0] p;
    p = 13'(v) * 13'd43;
    return p[12:7];
  endfunction

endpackage

/* design/haar_feature_from_integral_image_top.sv */
// top level of the haar feature evaluator over a stored integral image
//
//  channel | valid     | stall      | payload
//  --------+-----------+------------+------------------------
//  input   | in_valid_i| in_stall_o | in_data_i  (in_item_t)
//  output  | out_valid_o| out_stall_i| out_data_o (out_item_t)
//
// a write item is taken while idle, does not hold the input and gives no result
// an evaluate item holds the input until its result is in the output register, one corner read
// per cycle from the single port image store; an unknown kind skips the corner reads
// the result waits in an output register, so a stalled output only delays the next evaluate
// reset clears control only; image entries are undefined until written
`include "haar_feature_from_integral_image_top_macros.svh"

module haar_feature_from_integral_image_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  haar_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output haar_pkg::out_item_t out_data_o
);
  import haar_pkg::*;

  logic      in_accept, busy, out_free;
  ctrl_t     ctrl;
  out_item_t res;
  logic      out_valid_q;
  out_item_t out_data_q;

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i & ~busy;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  haar_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .action_i       (in_data_i.action),
    .feature_kind_i (in_data_i.feature_kind),
    .out_free_i     (out_free),
    .ctrl_o         (ctrl),
    .busy_o         (busy)
  );

  haar_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .in_data_i (in_data_i),
    .res_o     (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `HAAR_ASSERT(a_eval_busy, (in_accept && (in_data_i.action == ACT_EVAL)) |=> in_stall_o)
  `HAAR_ASSERT(a_write_free, (in_accept && (in_data_i.action == ACT_WRITE)) |=> !in_stall_o)
  `HAAR_ASSERT(a_err_zero, (out_valid_o && out_data_o.error_flag) |-> (out_data_o.feature_value == '0))
  `HAAR_ASSERT_RST(a_rst_empty, !rst_ni |-> !out_valid_o)

endmodule

/* design/haar_seq.sv */
// microcode sequencer: dispatch, step counter and control word issue
`include "haar_feature_from_integral_image_top_macros.svh"

module haar_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          action_i,
  input  logic [2:0]    feature_kind_i,
  input  logic          out_free_i,
  output haar_pkg::ctrl_t ctrl_o,
  output logic          busy_o
);
  import haar_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SPLIT = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uw;
  ctrl_t           ctrl;

  assign uw = ucode_rom(pc_q);

  always_comb begin
    ctrl    = '0;
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          if (action_i == ACT_WRITE) begin
            ctrl.wr = 1'b1;
          end else begin
            ctrl.load = 1'b1;
            if (kind_ok(feature_kind_i)) begin
              pc_d    = entry_pc(feature_kind_i);
              state_d = S_SPLIT;
            end else begin
              ctrl.kind_err = 1'b1;
              state_d       = S_DONE;
            end
          end
        end
      end
      S_SPLIT: begin
        ctrl.split = 1'b1;
        state_d    = S_RUN;
      end
      S_RUN: begin
        ctrl.issue = 1'b1;
        ctrl.xs    = uw.xs;
        ctrl.ys    = uw.ys;
        ctrl.wt    = uw.wt;
        if (uw.op == OP_LAST) begin
          state_d = S_DRAIN;
        end else begin
          pc_d = pc_q + PC_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          ctrl.finish = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  assign ctrl_o = ctrl;
  assign busy_o = (state_q != S_IDLE);

  `HAAR_ASSERT(a_pc_range, (state_q == S_RUN) |-> (pc_q < PC_W'(ROM_DEPTH)))
  `HAAR_ASSERT(a_one_op, $onehot0({ctrl.wr, ctrl.load, ctrl.split, ctrl.issue, ctrl.finish}))

endmodule

/* design/haar_dp.sv */
// datapath: corner coordinates, image store, weighted accumulator
module haar_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  haar_pkg::ctrl_t    ctrl_i,
  input  haar_pkg::in_item_t in_data_i,
  output haar_pkg::out_item_t res_o
);
  import haar_pkg::*;

  localparam logic signed [CW-1:0] ONE    = CW'(1);
  localparam logic signed [CW-1:0] LIMIT  = CW'(IMG_WIDTH);

  logic [VAL_W-1:0] mem_q [STORE_DEPTH];

  logic signed [CW-1:0] x_q, y_q;
  logic [5:0]           w_q, h_q;
  logic signed [CW-1:0] xm_q, x1_q, x2_q, xr_q;
  logic signed [CW-1:0] ym_q, y1_q, y2_q, yb_q;
  logic signed [CW-1:0] cx, cy;
  logic [IDX_W-1:0]     idx;
  logic                 neg, bad;
  logic [VAL_W-1:0]     rd_q;
  logic                 zero_q;
  wt_e                  wt_q;
  logic                 acc_en_q, err_q;
  logic signed [ACC_W-1:0] acc_q, base, wv;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= $signed(CW'(in_data_i.origin_x)) - ONE;
      y_q <= $signed(CW'(in_data_i.origin_y)) - ONE;
      w_q <= in_data_i.rect_width;
      h_q <= in_data_i.rect_height;
    end
    if (ctrl_i.split) begin
      xm_q <= x_q + $signed(CW'(w_q >> 1));
      x1_q <= x_q + $signed(CW'(div3({1'b0, w_q})));
      x2_q <= x_q + $signed(CW'(div3({w_q, 1'b0})));
      xr_q <= x_q + $signed(CW'(w_q));
      ym_q <= y_q + $signed(CW'(h_q >> 1));
      y1_q <= y_q + $signed(CW'(div3({1'b0, h_q})));
      y2_q <= y_q + $signed(CW'(div3({h_q, 1'b0})));
      yb_q <= y_q + $signed(CW'(h_q));
    end
  end

  always_comb begin
    case (ctrl_i.xs)
      XS_HALF:   cx = xm_q;
      XS_THIRD1: cx = x1_q;
      XS_THIRD2: cx = x2_q;
      XS_END:    cx = xr_q;
      default:   cx = x_q;
    endcase
    case (ctrl_i.ys)
      YS_HALF:   cy = ym_q;
      YS_THIRD1: cy = y1_q;
      YS_THIRD2: cy = y2_q;
      YS_END:    cy = yb_q;
      default:   cy = y_q;
    endcase
  end

  assign idx = IDX_W'(unsigned'(cy)) * IDX_W'(IMG_WIDTH) + IDX_W'(unsigned'(cx));
  assign neg = cx[CW-1] | cy[CW-1];
  assign bad = (cx >= LIMIT) || (cy >= LIMIT) ||
               (!neg && (idx >= IDX_W'(STORE_DEPTH)));

  // single port image store
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem_q[in_data_i.entry_index] <= in_data_i.entry_value;
    end else if (ctrl_i.issue && !bad && !neg) begin
      rd_q <= mem_q[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= bad | neg;
    wt_q   <= ctrl_i.wt;
  end

  always_comb begin
    base = zero_q ? '0 : $signed(ACC_W'(rd_q));
    case (wt_q)
      WT_P1:   wv = base;
      WT_P2:   wv = base <<< 1;
      WT_P4:   wv = base <<< 2;
      WT_N1:   wv = -base;
      WT_N2:   wv = -(base <<< 1);
      default: wv = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      acc_en_q <= ctrl_i.issue;
      if (ctrl_i.load) begin
        err_q <= ctrl_i.kind_err;
      end else if (ctrl_i.issue && bad) begin
        err_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= '0;
    end else if (acc_en_q) begin
      acc_q <= acc_q + wv;
    end
  end

  assign res_o.error_flag    = err_q;
  assign res_o.feature_value = err_q ? '0 : $signed(acc_q[FV_W-1:0]);

endmodule

/* bench/tb_haar_feature_from_integral_image_top.sv */
`timescale 1ns / 1ps
// self-checking bench for the haar feature evaluator: image writes and feature evaluations
module tb_haar_feature_from_integral_image_top;
  import haar_pkg::*;

  localparam int IMG_W        = IMG_WIDTH;
  localparam int NUM_ITEMS    = 1950;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_LIMIT  = 50;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b1;
  logic      in_valid_q  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_q   = '0;
  logic      out_valid_o;
  logic      out_stall_q = 1'b1;
  out_item_t out_data_o;

  in_item_t    stimulus_items[$];
  out_item_t   expected_features[$];
  logic [17:0] integral_copy [STORE_DEPTH];
  bit          entry_loaded [STORE_DEPTH];
  bit          corner_err;
  bit          send_calm;
  bit          recv_calm;
  int          send_wait;
  int          stall_left;
  int          idle_cycles;
  int          fail_count;
  int          queued;

  haar_feature_from_integral_image_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_q),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what);
    if (fail_count < PRINT_LIMIT) $display("%0t: mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = ~calm;
    return calm ? 0 : int'($urandom_range(0, 18));
  endfunction

  function automatic in_item_t random_bits();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [17:0] draw_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return 18'($urandom);
    endcase
  endfunction

  function automatic void queue_write(int idx, logic [17:0] value);
    in_item_t t;
    t = random_bits();
    t.action      = ACT_WRITE;
    t.entry_index = 10'(idx);
    t.entry_value = value;
    entry_loaded[idx] = 1'b1;
    stimulus_items.push_back(t);
    queued++;
  endfunction

  function automatic void queue_feature(int ox, int oy, int w, int h, logic [2:0] kind);
    in_item_t t;
    int       xs[5];
    int       ys[5];
    t = random_bits();
    t.action       = ACT_EVAL;
    t.origin_x     = 6'(ox);
    t.origin_y     = 6'(oy);
    t.rect_width   = 6'(w);
    t.rect_height  = 6'(h);
    t.feature_kind = kind;
    xs = '{ox - 1, ox - 1 + w / 2, ox - 1 + w / 3, ox - 1 + w * 2 / 3, ox - 1 + w};
    ys = '{oy - 1, oy - 1 + h / 2, oy - 1 + h / 3, oy - 1 + h * 2 / 3, oy - 1 + h};
    // any in-image corner the evaluation may touch gets written first
    foreach (xs[i])
      foreach (ys[j])
        if (xs[i] >= 0 && xs[i] < IMG_W && ys[j] >= 0 && ys[j] < IMG_W &&
            !entry_loaded[ys[j] * IMG_W + xs[i]])
          queue_write(ys[j] * IMG_W + xs[i], draw_value());
    stimulus_items.push_back(t);
    queued++;
  endfunction

  function automatic int integral_at(int cx, int cy);
    if (cx >= IMG_W || cy >= IMG_W) begin
      corner_err = 1'b1;
      return 0;
    end
    if (cx < 0 || cy < 0) return 0;
    return int'(integral_copy[cy * IMG_W + cx]);
  endfunction

  function automatic out_item_t predict_feature(in_item_t it);
    int        x;
    int        y;
    int        w;
    int        h;
    int        s;
    out_item_t r;
    x = int'(it.origin_x) - 1;
    y = int'(it.origin_y) - 1;
    w = int'(it.rect_width);
    h = int'(it.rect_height);
    s = 0;
    corner_err = 1'b0;
    case (it.feature_kind)
      KIND_VERT2: begin
        s = integral_at(x + w, y + h) + 2 * integral_at(x, y + h / 2)
          - 2 * integral_at(x + w, y + h / 2) - integral_at(x, y + h)
          - integral_at(x, y) + integral_at(x + w, y);
      end
      KIND_HORIZ2: begin
        s = 2 * integral_at(x + w / 2, y + h) + integral_at(x, y)
          - 2 * integral_at(x + w / 2, y) - integral_at(x + w, y + h)
          + integral_at(x + w, y) - integral_at(x, y + h);
      end
      KIND_VERT3: begin
        s = 2 * integral_at(x + w, y + h / 3) + 2 * integral_at(x, y + h * 2 / 3)
          + integral_at(x, y) + integral_at(x + w, y + h)
          - 2 * integral_at(x, y + h / 3) - 2 * integral_at(x + w, y + h * 2 / 3)
          - integral_at(x + w, y) - integral_at(x, y + h);
      end
      KIND_HORIZ3: begin
        s = 2 * integral_at(x + w / 3, y + h) + 2 * integral_at(x + w * 2 / 3, y)
          + integral_at(x, y) + integral_at(x + w, y + h)
          - 2 * integral_at(x + w / 3, y) - 2 * integral_at(x + w * 2 / 3, y + h)
          - integral_at(x + w, y) - integral_at(x, y + h);
      end
      KIND_CHECKER: begin
        s = 4 * integral_at(x + w / 2, y + h / 2)
          + integral_at(x, y) + integral_at(x + w, y)
          + integral_at(x, y + h) + integral_at(x + w, y + h)
          - 2 * integral_at(x + w / 2, y) - 2 * integral_at(x, y + h / 2)
          - 2 * integral_at(x + w, y + h / 2) - 2 * integral_at(x + w / 2, y + h);
      end
      default: corner_err = 1'b1;
    endcase
    r.error_flag    = corner_err;
    r.feature_value = corner_err ? '0 : 23'(s);
    return r;
  endfunction

  function automatic void absorb_item(in_item_t it);
    if (it.action == ACT_WRITE) integral_copy[it.entry_index] = it.entry_value;
    else expected_features.push_back(predict_feature(it));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : send_side
    logic nv;
    int   nw;
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_data_q  <= '0;
      send_wait  <= 0;
    end else begin
      nv = in_valid_q;
      nw = send_wait;
      if (in_valid_q && !in_stall_o) begin
        absorb_item(in_data_q);
        nv = 1'b0;
        nw = draw_gap(send_calm);
      end
      if (!nv) begin
        if (nw > 0) begin
          nw--;
        end else if (stimulus_items.size() > 0) begin
          in_data_q <= stimulus_items.pop_front();
          nv = 1'b1;
        end
      end
      in_valid_q <= nv;
      send_wait  <= nw;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : recv_side
    out_item_t want;
    int        nl;
    if (!rst_ni) begin
      out_stall_q <= 1'b1;
      stall_left  <= 0;
    end else begin
      nl = stall_left;
      if (out_valid_o && !out_stall_q) begin
        if (expected_features.size() == 0) begin
          report_mismatch("result transfer with no evaluation pending");
        end else begin
          want = expected_features.pop_front();
          if (out_data_o.feature_value !== want.feature_value)
            report_mismatch($sformatf("feature_value %0d, expected %0d",
                                      out_data_o.feature_value, want.feature_value));
          if (out_data_o.error_flag !== want.error_flag)
            report_mismatch($sformatf("error_flag %b, expected %b",
                                      out_data_o.error_flag, want.error_flag));
        end
        nl = draw_gap(recv_calm);
      end
      if (nl > 0) begin
        out_stall_q <= 1'b1;
        stall_left  <= nl - 1;
      end else begin
        out_stall_q <= 1'b0;
        stall_left  <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_q && !in_stall_o) || (out_valid_o && !out_stall_q)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("** haar_feature_from_integral_image_top: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int pick;
    int ox;
    int oy;

    rst_ni <= 1'b0;

    // directed: value extremes, every kind over the whole image, edge corners, errors
    queue_write(0, '1);
    queue_write(STORE_DEPTH - 1, '1);
    for (int k = KIND_VERT2; k <= KIND_CHECKER; k++) queue_feature(0, 0, IMG_W, IMG_W, 3'(k));
    queue_feature(IMG_W, IMG_W, 0, 0, KIND_CHECKER);
    queue_feature(0, 0, 0, 0, KIND_VERT2);
    queue_feature(3, 5, 7, 11, KIND_VERT3);
    queue_feature(2, 2, 11, 7, KIND_HORIZ3);
    queue_feature(IMG_W + 1, 1, 1, 1, KIND_VERT2);
    queue_feature(1, IMG_W + 1, 4, 4, KIND_HORIZ2);
    queue_feature(1, 1, 63, 63, KIND_CHECKER);
    queue_feature(63, 63, 63, 63, KIND_HORIZ3);
    queue_feature(1, 1, 2, 2, KIND_NONE);
    queue_feature(1, 1, 2, 2, KIND_SPARE6);
    queue_feature(1, 1, 2, 2, KIND_SPARE7);

    // random: mostly in-image features, some overwrites, out-of-image and junk items
    while (queued < NUM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        queue_write($urandom_range(0, STORE_DEPTH - 1), draw_value());
      end else if (pick < 75) begin
        ox = $urandom_range(0, IMG_W);
        oy = $urandom_range(0, IMG_W);
        queue_feature(ox, oy, $urandom_range(0, IMG_W - ox), $urandom_range(0, IMG_W - oy),
                      3'($urandom_range(KIND_VERT2, KIND_CHECKER)));
      end else if (pick < 88) begin
        queue_feature($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 63), 3'($urandom_range(KIND_VERT2, KIND_CHECKER)));
      end else begin
        queue_feature($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 63), 3'($urandom_range(0, 7)));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (stimulus_items.size() > 0 || in_valid_q || expected_features.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("** haar_feature_from_integral_image_top: PASSED **");
    else $display("** haar_feature_from_integral_image_top: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/haar_pkg.sv
design/haar_seq.sv
design/haar_dp.sv
design/haar_feature_from_integral_image_top.sv
bench/tb_haar_feature_from_integral_image_top.sv
